// ----- rtl/core/dfm_pkg.sv -----
`default_nettype none
package dfm_pkg;

    // operand classes decided by the front
    localparam logic [1:0] CLS_NAN   = 2'd0;
    localparam logic [1:0] CLS_EQUAL = 2'd1;
    localparam logic [1:0] CLS_SMALL = 2'd2;
    localparam logic [1:0] CLS_GEN   = 2'd3;

    localparam logic [7:0]  BIAS        = 8'd101;
    localparam logic [7:0]  BE_MAX      = 8'd191;
    localparam logic [23:0] COEFF_MAX   = 24'd9999999;
    localparam logic [31:0] NAN_BITS    = 32'h7C00_0000;
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    typedef struct packed {
        logic        special;
        logic        sign;
        logic [7:0]  be;
        logic [23:0] coeff;
    } dfm_dec_t;

    typedef struct packed {
        logic [1:0]  cls;
        logic        sign;
        logic [7:0]  xe;
        logic [7:0]  ye;
        logic [23:0] xc;
        logic [23:0] yc;
    } dfm_item_t;

    // split a bid word into sign, biased exponent and coefficient
    function automatic dfm_dec_t dfm_unpack(input logic [31:0] w);
        dfm_dec_t v;
        v.special = 1'b0;
        v.sign    = w[31];
        if (w[30:29] == 2'b11)
        begin
            v.be    = w[28:21];
            v.coeff = {3'b100, w[20:0]};
            if (w[30:27] == 4'b1111)
            begin
                v.special = 1'b1;
                v.be      = '0;
                v.coeff   = '0;
            end
            else if (v.coeff > COEFF_MAX)
            begin
                v.coeff = '0;
            end
        end
        else
        begin
            v.be    = w[30:23];
            v.coeff = {1'b0, w[22:0]};
        end
        return v;
    endfunction

    function automatic logic [31:0] dfm_pack(input logic sign, input logic [7:0] be,
                                             input logic [23:0] coeff);
        logic [31:0] w;
        if (coeff[23] == 1'b0)
            w = {sign, be, coeff[22:0]};
        else
            w = {sign, 2'b11, be, coeff[20:0]};
        return w;
    endfunction

    // number of decimal digits of a coefficient, one to seven
    function automatic logic [2:0] dfm_digits(input logic [23:0] c);
        logic [2:0] n;
        n = 3'd1;
        if (c >= 24'd10)      n = 3'd2;
        if (c >= 24'd100)     n = 3'd3;
        if (c >= 24'd1000)    n = 3'd4;
        if (c >= 24'd10000)   n = 3'd5;
        if (c >= 24'd100000)  n = 3'd6;
        if (c >= 24'd1000000) n = 3'd7;
        return n;
    endfunction

    function automatic logic [19:0] dfm_pow10(input logic [2:0] k);
        logic [19:0] p;
        case (k)
            3'd0:    p = 20'd1;
            3'd1:    p = 20'd10;
            3'd2:    p = 20'd100;
            3'd3:    p = 20'd1000;
            3'd4:    p = 20'd10000;
            3'd5:    p = 20'd100000;
            3'd6:    p = 20'd1000000;
            default: p = 20'd1;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/dfm_front.sv -----
`default_nettype none
module dfm_front (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    s_tvalid,
    output logic                   s_tready,
    input  wire  [63:0]            s_tdata,
    output logic                   q_valid,
    input  wire                    q_ready,
    output dfm_pkg::dfm_item_t     q_item
);
    import dfm_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_CMP  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]  state_reg, state_next;
    dfm_dec_t    x_reg, y_reg;
    logic        gt_reg, lt_reg;
    logic [43:0] ca_reg, cb_reg;

    dfm_dec_t    dx, dy;
    logic [8:0]  adj_x, adj_y;
    logic [7:0]  gap;
    logic [2:0]  gap_s;
    logic [23:0] mul_op;
    logic [43:0] prod;
    logic [1:0]  cls;

    assign dx = dfm_unpack(s_tdata[31:0]);
    assign dy = dfm_unpack(s_tdata[63:32]);
    assign s_tready = (state_reg == F_IDLE);

    // adjusted exponents and the scaled coefficients for an equal-adjusted compare
    always_comb
    begin
        adj_x = {1'b0, x_reg.be} + {6'd0, dfm_digits(x_reg.coeff)};
        adj_y = {1'b0, y_reg.be} + {6'd0, dfm_digits(y_reg.coeff)};
        gap   = (x_reg.be >= y_reg.be) ? (x_reg.be - y_reg.be) : (y_reg.be - x_reg.be);
        gap_s = (gap > 8'd6) ? 3'd0 : gap[2:0];
        mul_op = (x_reg.be > y_reg.be) ? x_reg.coeff : y_reg.coeff;
        prod  = mul_op * dfm_pow10(gap_s);
    end

    // classification
    always_comb
    begin
        if (x_reg.special || y_reg.special || y_reg.coeff == '0)
            cls = CLS_NAN;
        else if (x_reg.coeff == '0)
            cls = CLS_SMALL;
        else if (gt_reg)
            cls = CLS_GEN;
        else if (lt_reg)
            cls = CLS_SMALL;
        else if (ca_reg == cb_reg)
            cls = CLS_EQUAL;
        else if (ca_reg > cb_reg)
            cls = CLS_GEN;
        else
            cls = CLS_SMALL;
    end

    always_comb
    begin
        q_valid     = (state_reg == F_PUSH);
        q_item.cls  = cls;
        q_item.sign = x_reg.sign;
        q_item.xe   = x_reg.be;
        q_item.ye   = y_reg.be;
        q_item.xc   = x_reg.coeff;
        q_item.yc   = y_reg.coeff;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:  if (s_tvalid) state_next = F_CMP;
            F_CMP:   state_next = F_PUSH;
            F_PUSH:  if (q_ready) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    // operand and compare registers
    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && s_tvalid)
        begin
            x_reg <= dx;
            y_reg <= dy;
        end
        if (state_reg == F_CMP)
        begin
            gt_reg <= (adj_x > adj_y);
            lt_reg <= (adj_x < adj_y);
            if (x_reg.be > y_reg.be)
            begin
                ca_reg <= prod;
                cb_reg <= {20'd0, y_reg.coeff};
            end
            else
            begin
                ca_reg <= {20'd0, x_reg.coeff};
                cb_reg <= prod;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/dfm_queue.sv -----
`default_nettype none
module dfm_queue (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  dfm_pkg::dfm_item_t     in_item,
    output logic                   out_valid,
    input  wire                    out_ready,
    output dfm_pkg::dfm_item_t     out_item
);
    import dfm_pkg::*;

    dfm_item_t  mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_item  = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= in_item;
    end

endmodule
`default_nettype wire

// ----- rtl/core/dfm_back.sv -----
`default_nettype none
module dfm_back (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    q_valid,
    output logic                   q_ready,
    input  dfm_pkg::dfm_item_t     q_item,
    output logic                   m_tvalid,
    input  wire                    m_tready,
    output logic [31:0]            m_tdata,
    output logic                   m_tuser
);
    import dfm_pkg::*;

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_SCALE = 3'd1;
    localparam logic [2:0] B_MULT  = 3'd2;
    localparam logic [2:0] B_DIV   = 3'd3;
    localparam logic [2:0] B_DIGIT = 3'd4;
    localparam logic [2:0] B_STRA  = 3'd5;
    localparam logic [2:0] B_STRB  = 3'd6;
    localparam logic [2:0] B_HOLD  = 3'd7;

    logic [2:0]  state_reg;
    logic        sign_reg;
    logic [23:0] xc_reg, m_reg, r_reg, q_reg;
    logic [7:0]  k_reg, re_reg;
    logic [2:0]  d_reg;
    logic [4:0]  cnt_reg;
    logic [27:0] mul_reg [1:9];
    logic [31:0] res_reg;
    logic        err_reg;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic        out_err_reg;

    logic [24:0] rr;
    logic [27:0] r10, r10_sub;
    logic [55:0] qprod;
    logic [25:0] q10;
    logic        out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_err_reg;
    assign out_free = !out_valid_reg || m_tready;
    assign q_ready  = (state_reg == B_IDLE);

    // datapath for one division bit, one remainder digit and one strip check
    always_comb
    begin
        rr = {r_reg, xc_reg[cnt_reg]};
        r10 = {r_reg, 3'b000} + {3'b000, r_reg, 1'b0};
        r10_sub = r10;
        for (int j = 1; j <= 9; j++)
        begin
            if (r10 >= mul_reg[j])
                r10_sub = r10 - mul_reg[j];
        end
        qprod = r_reg * RECIP_TEN;
        q10   = {q_reg[22:0], 3'b000} + {1'b0, q_reg, 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                B_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (q_item.cls == CLS_GEN) state_reg <= B_SCALE;
                        else                       state_reg <= B_HOLD;
                    end
                end
                B_SCALE: if (d_reg == 3'd0) state_reg <= B_MULT;
                B_MULT:  state_reg <= B_DIV;
                B_DIV:   if (cnt_reg == 5'd0) state_reg <= B_DIGIT;
                B_DIGIT: if (k_reg == 8'd0) state_reg <= B_STRA;
                B_STRA:  if (r_reg == '0) state_reg <= B_HOLD;
                         else state_reg <= B_STRB;
                B_STRB:
                begin
                    if (q10 == {2'b00, r_reg} && re_reg < BE_MAX) state_reg <= B_STRA;
                    else                                         state_reg <= B_HOLD;
                end
                B_HOLD:  if (out_free) state_reg <= B_IDLE;
                default: state_reg <= B_IDLE;
            endcase
            if (state_reg == B_HOLD && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // working registers of the remainder sequencer
    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                sign_reg <= q_item.sign;
                xc_reg   <= q_item.xc;
                m_reg    <= q_item.yc;
                r_reg    <= '0;
                cnt_reg  <= 5'd23;
                err_reg  <= 1'b0;
                if (q_item.ye > q_item.xe)
                begin
                    d_reg  <= 3'(q_item.ye - q_item.xe);
                    k_reg  <= '0;
                    re_reg <= q_item.xe;
                end
                else
                begin
                    d_reg  <= '0;
                    k_reg  <= q_item.xe - q_item.ye;
                    re_reg <= q_item.ye;
                end
                case (q_item.cls)
                    CLS_NAN:
                    begin
                        res_reg <= NAN_BITS;
                        err_reg <= 1'b1;
                    end
                    CLS_EQUAL: res_reg <= dfm_pack(q_item.sign, BIAS, '0);
                    default:   res_reg <= dfm_pack(q_item.sign, q_item.xe, q_item.xc);
                endcase
            end
            B_SCALE:
            begin
                if (d_reg != 3'd0)
                begin
                    m_reg <= 24'({m_reg, 3'b000} + {2'b00, m_reg, 1'b0});
                    d_reg <= d_reg - 3'd1;
                end
            end
            B_MULT:
            begin
                for (int j = 1; j <= 9; j++)
                    mul_reg[j] <= 28'(m_reg) * 28'(j);
            end
            B_DIV:
            begin
                if (rr >= {1'b0, m_reg}) r_reg <= 24'(rr - {1'b0, m_reg});
                else                     r_reg <= rr[23:0];
                cnt_reg <= cnt_reg - 5'd1;
            end
            B_DIGIT:
            begin
                if (k_reg != 8'd0)
                begin
                    r_reg <= r10_sub[23:0];
                    k_reg <= k_reg - 8'd1;
                end
            end
            B_STRA:
            begin
                q_reg <= qprod[RECIP_SHIFT +: 24];
                if (r_reg == '0)
                    res_reg <= dfm_pack(sign_reg, BIAS, '0);
            end
            B_STRB:
            begin
                if (q10 == {2'b00, r_reg} && re_reg < BE_MAX)
                begin
                    r_reg  <= q_reg;
                    re_reg <= re_reg + 8'd1;
                end
                else
                begin
                    res_reg <= dfm_pack(sign_reg, re_reg, r_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (state_reg == B_HOLD && out_free)
        begin
            out_data_reg <= res_reg;
            out_err_reg  <= err_reg;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/decimal32_fmod_unit_core.sv -----
// decimal32 remainder unit, bid encoding
// slave channel: s_tdata carries dividend then divisor, one operand pair per beat
// master channel: m_tdata carries the remainder, m_tuser the domain error flag
// special operands or a zero divisor give the canonical quiet nan with the flag set
// a front stage decodes a beat, compares and classifies it, then hands it to a
// two-entry queue; the back stage then works one item at a time
// special, equal and smaller-dividend cases go from idle straight to the output hold state
// the general case runs up to six scale-by-ten steps, a bit-serial binary division,
// one digit step per unit of exponent difference (up to 191), then up to six
// trailing-zero strips, each a reciprocal step and a check step
// the front keeps accepting while the back works until the queue fills
// a finished result sits in the output register until m_tready; the back
// stalls with it and the queue then backs up to s_tready
// reset clears all handshake state; no beat is pending afterwards
`default_nettype none
module decimal32_fmod_unit_core (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,    // dividend_bits[31:0], divisor_bits[63:32]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,    // remainder_bits[31:0]
    output logic        m_tuser     // domain_error[0]
);
    import dfm_pkg::*;

    logic      fq_valid, fq_ready, qb_valid, qb_ready;
    dfm_item_t fq_item, qb_item;

    dfm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_item   (fq_item)
    );

    dfm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    dfm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (qb_valid),
        .q_ready  (qb_ready),
        .q_item   (qb_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

// ----- tb/decimal32_fmod_unit_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module decimal32_fmod_unit_checker (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [63:0] s_tdata,
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [31:0] m_tdata,
    input  wire         m_tuser,
    output int          fail_count,
    output int          pending_count
);

    typedef struct {
        logic        special;
        logic        sign;
        int          expo;
        longint      coeff;
    } operand_t;

    typedef struct {
        logic [31:0] rem;
        logic        derr;
    } rem_result_t;

    rem_result_t remainder_queue[$];

    // split a bid word into its fields, non-canonical coefficient reads as zero
    function automatic operand_t split_word(input logic [31:0] w);
        operand_t v;
        v.special = 1'b0;
        v.sign    = w[31];
        v.expo    = 0;
        v.coeff   = 0;
        if (w[30:29] == 2'b11)
        begin
            if (w[30:27] == 4'b1111)
                v.special = 1'b1;
            else
            begin
                v.expo  = int'(w[28:21]) - 101;
                v.coeff = longint'({3'b100, w[20:0]});
                if (v.coeff > 9999999)
                    v.coeff = 0;
            end
        end
        else
        begin
            v.expo  = int'(w[30:23]) - 101;
            v.coeff = longint'(w[22:0]);
        end
        return v;
    endfunction

    function automatic logic [31:0] join_word(input logic sign, input int expo,
                                              input longint coeff);
        logic [7:0]  be;
        logic [23:0] c;
        be = 8'(expo + 101);
        c  = 24'(coeff);
        if (!c[23])
            return {sign, be, c[22:0]};
        return {sign, 2'b11, be, c[20:0]};
    endfunction

    function automatic int digit_count(input longint c);
        int n;
        n = 1;
        while (c >= 10)
        begin
            c = c / 10;
            n++;
        end
        return n;
    endfunction

    function automatic longint ten_pow(input int k);
        longint p;
        p = 1;
        repeat (k) p = p * 10;
        return p;
    endfunction

    // exact remainder of x by y with the sign of x
    function automatic rem_result_t predict_remainder(input logic [63:0] d);
        operand_t    x, y;
        rem_result_t o;
        int          c, ax, ay, re, k;
        longint      cx, cy, r;
        x = split_word(d[31:0]);
        y = split_word(d[63:32]);
        o.derr = 1'b0;
        if (x.special || y.special || y.coeff == 0)
        begin
            o.rem  = 32'h7C00_0000;
            o.derr = 1'b1;
            return o;
        end
        if (x.coeff == 0)
            c = -1;
        else
        begin
            ax = x.expo + digit_count(x.coeff);
            ay = y.expo + digit_count(y.coeff);
            cx = x.coeff;
            cy = y.coeff;
            if (ax != ay)
                c = (ax > ay) ? 1 : -1;
            else
            begin
                if (x.expo > y.expo)
                    cx = cx * ten_pow(x.expo - y.expo);
                else
                    cy = cy * ten_pow(y.expo - x.expo);
                c = (cx == cy) ? 0 : ((cx > cy) ? 1 : -1);
            end
        end
        if (c == 0)
            o.rem = join_word(x.sign, 0, 0);
        else if (c < 0)
            o.rem = join_word(x.sign, x.expo, x.coeff);
        else
        begin
            if (x.expo >= y.expo)
            begin
                r = x.coeff % y.coeff;
                for (k = x.expo - y.expo; k > 0; k--)
                    r = (r * 10) % y.coeff;
                re = y.expo;
            end
            else
            begin
                r  = x.coeff % (y.coeff * ten_pow(y.expo - x.expo));
                re = x.expo;
            end
            if (r == 0)
                re = 0;
            else
                while (r % 10 == 0 && re < 90)
                begin
                    r = r / 10;
                    re++;
                end
            o.rem = join_word(x.sign, re, r);
        end
        return o;
    endfunction

    assign pending_count = remainder_queue.size();

    // predict on each accepted input beat, compare on each output beat
    always @(posedge clk)
    begin
        rem_result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                remainder_queue.push_back(predict_remainder(s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (remainder_queue.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result beat %h err %b", m_tdata, m_tuser);
                end
                else
                begin
                    want = remainder_queue.pop_front();
                    if (want.rem !== m_tdata || want.derr !== m_tuser)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %h err %b, got %h err %b",
                                     want.rem, want.derr, m_tdata, m_tuser);
                    end
                end
            end
        end
    end

    initial fail_count = 0;

endmodule
`default_nettype wire

// ----- tb/decimal32_fmod_unit_core_test.sv -----
`timescale 1ns / 1ps
`default_nettype none
module decimal32_fmod_unit_core_test;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;
    int          fail_count;
    int          pending_count;
    int          idle_cycles;

    decimal32_fmod_unit_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    decimal32_fmod_unit_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // build a word in the short-coefficient form
    function automatic logic [31:0] short_word(input logic sign, input int expo,
                                               input int unsigned coeff);
        logic [7:0] be;
        be = 8'(expo + 101);
        return {sign, be, 23'(coeff)};
    endfunction

    // mostly short-form operands with small exponents, with some random, long-form and special words
    function automatic logic [31:0] random_operand();
        int unsigned kind;
        int unsigned c;
        kind = $urandom_range(0, 9);
        case (kind)
            0: return $urandom();
            1: return {$urandom_range(0, 1) == 1, 2'b11, 8'($urandom_range(0, 191)),
                       21'($urandom())};
            2: return {$urandom_range(0, 1) == 1, 4'b1111, 27'($urandom())};
            default:
            begin
                c = $urandom_range(0, 3) == 0 ? $urandom_range(0, 99)
                                              : $urandom_range(0, 8388607);
                return short_word($urandom_range(0, 1) == 1,
                                  $urandom_range(0, 3) == 0 ? $urandom_range(0, 190) - 101
                                                            : $urandom_range(0, 12) - 6,
                                  c);
            end
        endcase
    endfunction

    task automatic send_beat(input logic [31:0] x, input logic [31:0] y);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // receiver stalls drawn per result
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        int n;
        idle_cycles = 0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: specials, zero divisor, equal, smaller, extremes, clamp
        send_beat(32'h7C00_0000, short_word(0, 0, 3));
        send_beat(short_word(0, 0, 3), 32'hFC00_0000);
        send_beat(32'h7800_0000, short_word(0, 0, 3));
        send_beat(short_word(1, 0, 7), short_word(0, 5, 0));
        send_beat(short_word(1, 0, 50), short_word(0, 1, 5));
        send_beat(short_word(0, -2, 1234), short_word(1, 0, 99));
        send_beat(short_word(1, 0, 0), short_word(0, 0, 3));
        send_beat(short_word(0, 90, 9999999), short_word(0, -101, 7));
        send_beat(short_word(1, 90, 1), short_word(0, -101, 9999999));
        send_beat(short_word(0, 0, 1000), short_word(0, 0, 7));
        send_beat(short_word(0, 0, 100), short_word(0, -3, 3));
        send_beat(short_word(0, 80, 9999999), short_word(0, 50, 3));
        send_beat(32'hEB7F_FFFF, short_word(0, 0, 3));
        send_beat(32'h6CBF_FFFF, short_word(0, 0, 9));
        send_beat(short_word(0, 0, 9), 32'h6FFF_FFFF);
        send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(32'h0000_0000, 32'h0000_0000);
        send_beat(short_word(0, 90, 8388607), short_word(1, 90, 8388607));
        send_beat(short_word(1, -101, 1), short_word(0, -101, 1));
        send_beat(short_word(0, 0, 25), short_word(0, 0, 10));

        // hold off until the queue has drained
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);

        for (n = 0; n < 750; n++)
            send_beat(random_operand(), random_operand());
        s_tvalid <= 1'b0;

        while (pending_count != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
`default_nettype wire
